/* rtl/bilinear_texel_sampler_core_defines.svh */
// ---------------------------------------------------------------------------
// bilinear texel sampler assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ---------------------------------------------------------------------------
`ifndef BILINEAR_TEXEL_SAMPLER_CORE_DEFINES_SVH
`define BILINEAR_TEXEL_SAMPLER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define BTSC_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);
// checked at every edge, reset included
`define BTSC_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);
`else
`define BTSC_ASSERT(name, clk, rstn, prop, msg)
`define BTSC_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

/* rtl/btsc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// btsc_pkg
// shared constants, types and register codes of the texel sampler
// ---------------------------------------------------------------------------
package btsc_pkg;

    localparam int COL_BITS  = 8;
    localparam int ROW_BITS  = 8;
    localparam int FRAC_BITS = 16;

    localparam int COORD_W   = 48;
    localparam int DIM_W     = 9;
    localparam int RGBA_W    = 32;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 4;
    localparam int IN_COL_W  = 8;
    localparam int IN_ROW_W  = 8;

    localparam int MAX_BITS  = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
    localparam int INT_BITS  = MAX_BITS + 1;
    localparam int QUO_W     = INT_BITS + FRAC_BITS;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int NSAT_W    = MAX_BITS + 1;
    localparam int NM1_W     = MAX_BITS;
    localparam int PROD_W    = DIFF_W + NM1_W;
    localparam int REM_W     = DIFF_W + 1;
    localparam int POS_W     = MAX_BITS + FRAC_BITS;
    localparam int AX_LAT    = QUO_W + 4;

    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);

    localparam int NUM_BANKS  = 4;
    localparam int BANK_AW    = COL_BITS + ROW_BITS - 2;
    localparam int BANK_DEPTH = 1 << BANK_AW;

    localparam int WGT_W     = FRAC_BITS + 1;
    localparam int LERP_W    = CH_W + FRAC_BITS;
    localparam int ACC_W     = LERP_W + WGT_W;

    localparam logic [WGT_W-1:0] FRAC_ONE = WGT_W'(1) << FRAC_BITS;

    localparam int X_LIMIT = 1 << COL_BITS;
    localparam int Y_LIMIT = 1 << ROW_BITS;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN        = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN        = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX        = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX        = CFG_IDX_W'(5);

    typedef struct packed {
        logic                action;
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
        logic [RGBA_W-1:0]   rgba;
    } load_t;

    typedef struct packed {
        load_t                ld;
        logic                 in_range;
        logic [COL_BITS-1:0]  c0;
        logic [FRAC_BITS-1:0] fx;
        logic [ROW_BITS-1:0]  r0;
        logic [FRAC_BITS-1:0] fy;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

/* rtl/btsc_axis.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// btsc_axis
// maps one coordinate to a clamped fixed-point pixel position, pipelined
// ---------------------------------------------------------------------------
module btsc_axis (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic [btsc_pkg::COORD_W-1:0]         p,
    input  logic [btsc_pkg::COORD_W-1:0]         lo,
    input  logic [btsc_pkg::COORD_W-1:0]         hi,
    input  logic [btsc_pkg::NSAT_W-1:0]          n,
    output logic [btsc_pkg::POS_W-1:0]           pos,
    output logic                                 in_range
);

    localparam int DW = btsc_pkg::DIFF_W;
    localparam int QW = btsc_pkg::QUO_W;
    localparam int NW = btsc_pkg::NSAT_W;
    localparam int PW = btsc_pkg::PROD_W;
    localparam int IB = btsc_pkg::INT_BITS;
    localparam int FB = btsc_pkg::FRAC_BITS;

    // offset and span
    logic [DW-1:0] d_w, span_w;
    logic          bad_w;
    logic [DW-1:0] d1_reg, span1_reg;
    logic          bad1_reg;
    logic [NW-1:0] n1_reg;

    assign d_w    = {p[btsc_pkg::COORD_W-1], p} - {lo[btsc_pkg::COORD_W-1], lo};
    assign span_w = {hi[btsc_pkg::COORD_W-1], hi} - {lo[btsc_pkg::COORD_W-1], lo};
    assign bad_w  = (n == '0) || span_w[DW-1] || (span_w == '0);

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg    <= d_w;
            span1_reg <= span_w;
            bad1_reg  <= bad_w;
            n1_reg    <= n;
        end
    end

    // magnitude times (n - 1)
    logic [DW-1:0]                   mag_w;
    logic [btsc_pkg::NM1_W-1:0]      nm1_w;
    logic [PW-1:0]                   prod2_reg;
    logic [DW-1:0]                   span2_reg;
    logic                            bad2_reg, neg2_reg;
    logic [NW-1:0]                   n2_reg;

    assign mag_w = d1_reg[DW-1] ? (~d1_reg + DW'(1)) : d1_reg;
    assign nm1_w = btsc_pkg::NM1_W'(n1_reg - NW'(1));

    always_ff @(posedge aclk) begin
        if (en) begin
            prod2_reg <= PW'(mag_w) * PW'(nm1_w);
            span2_reg <= span1_reg;
            bad2_reg  <= bad1_reg;
            neg2_reg  <= d1_reg[DW-1];
            n2_reg    <= n1_reg;
        end
    end

    // range check, divider seed, then one quotient bit per stage
    logic          ovf_w;
    logic [DW-1:0] rem_reg  [QW+1];
    logic [QW-1:0] qd_reg   [QW+1];
    logic [DW-1:0] span_reg [QW+1];
    logic [NW-1:0] n_reg    [QW+1];
    logic          out_reg  [QW+1];
    logic          neg_reg  [QW+1];
    logic [btsc_pkg::REM_W-1:0] trial_w [QW];
    logic          ge_w     [QW];

    assign ovf_w = neg2_reg ? (prod2_reg >= PW'(span2_reg))
                            : ((prod2_reg >> IB) >= PW'(span2_reg));

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            trial_w[k] = {rem_reg[k], qd_reg[k][QW-1]};
            ge_w[k]    = trial_w[k] >= {1'b0, span_reg[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= DW'(prod2_reg >> IB);
            qd_reg[0]   <= {prod2_reg[IB-1:0], FB'(0)};
            span_reg[0] <= span2_reg;
            n_reg[0]    <= n2_reg;
            out_reg[0]  <= bad2_reg || ovf_w;
            neg_reg[0]  <= neg2_reg;
            for (int k = 0; k < QW; k++) begin
                rem_reg[k+1]  <= ge_w[k] ? DW'(trial_w[k] - {1'b0, span_reg[k]})
                                         : DW'(trial_w[k]);
                qd_reg[k+1]   <= {qd_reg[k][QW-2:0], ge_w[k]};
                span_reg[k+1] <= span_reg[k];
                n_reg[k+1]    <= n_reg[k];
                out_reg[k+1]  <= out_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
            end
        end
    end

    // range test and clamp to the last texel
    logic [QW-1:0]                 q_w;
    logic [btsc_pkg::POS_W-1:0]    lim_w, pos_w;
    logic                          in_w;
    logic [btsc_pkg::POS_W-1:0]    pos_reg;
    logic                          inside_reg;

    assign q_w   = qd_reg[QW];
    assign lim_w = {btsc_pkg::NM1_W'(n_reg[QW] - NW'(1)), FB'(0)};
    assign in_w  = !out_reg[QW] && (neg_reg[QW] || (q_w[QW-1:FB] < n_reg[QW]));
    assign pos_w = neg_reg[QW] ? '0
                 : ((q_w > QW'(lim_w)) ? lim_w : btsc_pkg::POS_W'(q_w));

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg    <= pos_w;
            inside_reg <= in_w;
        end
    end

    assign pos      = pos_reg;
    assign in_range = inside_reg;

endmodule

/* rtl/btsc_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// btsc_front
// accepts words, maps sample points to pixel space, feeds the queue
// ---------------------------------------------------------------------------
module btsc_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_action,
    input  logic [btsc_pkg::IN_COL_W-1:0]         s_texel_col,
    input  logic [btsc_pkg::IN_ROW_W-1:0]         s_texel_row,
    input  logic [btsc_pkg::RGBA_W-1:0]           s_texel_rgba,
    input  logic signed [btsc_pkg::COORD_W-1:0]   s_point_x,
    input  logic signed [btsc_pkg::COORD_W-1:0]   s_point_y,
    input  logic [btsc_pkg::DIM_W-1:0]            image_width,
    input  logic [btsc_pkg::DIM_W-1:0]            image_height,
    input  logic [btsc_pkg::COORD_W-1:0]          x_min,
    input  logic [btsc_pkg::COORD_W-1:0]          y_min,
    input  logic [btsc_pkg::COORD_W-1:0]          x_max,
    input  logic [btsc_pkg::COORD_W-1:0]          y_max,
    input  btsc_pkg::q_stat_t                     q_stat,
    output logic                                  q_push,
    output btsc_pkg::item_t                       q_word
);

    localparam int LAT = btsc_pkg::AX_LAT;

    logic en;
    assign en      = !q_stat.full;
    assign s_ready = en;

    // input register
    logic                           s0_valid_reg;
    btsc_pkg::load_t                s0_ld_reg;
    logic [btsc_pkg::COORD_W-1:0]   s0_px_reg, s0_py_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en) begin
            s0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_ld_reg.action <= s_action;
            s0_ld_reg.col    <= btsc_pkg::COL_BITS'(s_texel_col);
            s0_ld_reg.row    <= btsc_pkg::ROW_BITS'(s_texel_row);
            s0_ld_reg.rgba   <= s_texel_rgba;
            s0_px_reg        <= s_point_x;
            s0_py_reg        <= s_point_y;
        end
    end

    // sizes saturated to the store bounds
    logic [btsc_pkg::NSAT_W-1:0] nx_w, ny_w;
    assign nx_w = (32'(image_width) > 32'(btsc_pkg::X_LIMIT))
                ? btsc_pkg::NSAT_W'(btsc_pkg::X_LIMIT) : btsc_pkg::NSAT_W'(image_width);
    assign ny_w = (32'(image_height) > 32'(btsc_pkg::Y_LIMIT))
                ? btsc_pkg::NSAT_W'(btsc_pkg::Y_LIMIT) : btsc_pkg::NSAT_W'(image_height);

    logic [btsc_pkg::POS_W-1:0] posx_w, posy_w;
    logic                       inx_w, iny_w;

    btsc_axis u_axis_x (
        .aclk     (aclk),
        .en       (en),
        .p        (s0_px_reg),
        .lo       (x_min),
        .hi       (x_max),
        .n        (nx_w),
        .pos      (posx_w),
        .in_range (inx_w)
    );

    btsc_axis u_axis_y (
        .aclk     (aclk),
        .en       (en),
        .p        (s0_py_reg),
        .lo       (y_min),
        .hi       (y_max),
        .n        (ny_w),
        .pos      (posy_w),
        .in_range (iny_w)
    );

    // word tracking alongside the mapping pipeline
    logic            pipe_valid_reg [LAT];
    btsc_pkg::load_t pipe_ld_reg    [LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LAT; k++) begin
                pipe_valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            pipe_valid_reg[0] <= s0_valid_reg;
            for (int k = 1; k < LAT; k++) begin
                pipe_valid_reg[k] <= pipe_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_ld_reg[0] <= s0_ld_reg;
            for (int k = 1; k < LAT; k++) begin
                pipe_ld_reg[k] <= pipe_ld_reg[k-1];
            end
        end
    end

    assign q_push          = en && pipe_valid_reg[LAT-1];
    assign q_word.ld       = pipe_ld_reg[LAT-1];
    assign q_word.in_range = inx_w && iny_w;
    assign q_word.c0       = posx_w[btsc_pkg::FRAC_BITS +: btsc_pkg::COL_BITS];
    assign q_word.fx       = posx_w[btsc_pkg::FRAC_BITS-1:0];
    assign q_word.r0       = posy_w[btsc_pkg::FRAC_BITS +: btsc_pkg::ROW_BITS];
    assign q_word.fy       = posy_w[btsc_pkg::FRAC_BITS-1:0];

endmodule

/* rtl/btsc_queue.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// btsc_queue
// short fifo between the mapping front and the texel back end
// ---------------------------------------------------------------------------
`include "bilinear_texel_sampler_core_defines.svh"

module btsc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  btsc_pkg::item_t   push_word,
    input  logic              pop,
    output btsc_pkg::item_t   head,
    output btsc_pkg::q_stat_t stat
);

    localparam int PW = btsc_pkg::Q_PTR_W;

    btsc_pkg::item_t  mem_reg [btsc_pkg::Q_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]      count_reg;

    assign stat.full  = (count_reg == (PW+1)'(btsc_pkg::Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (PW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    `BTSC_ASSERT(a_push_not_full, aclk, aresetn, push |-> !stat.full, "push into full queue")
    `BTSC_ASSERT(a_pop_not_empty, aclk, aresetn, pop |-> !stat.empty, "pop from empty queue")
    `BTSC_ASSERT(a_count_up, aclk, aresetn, (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1), "queue count lost a push")
    `BTSC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> stat.empty, "queue not empty after reset")

endmodule

/* rtl/btsc_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// btsc_back
// banked texel store, four-texel fetch, bilinear blend and output register
// ---------------------------------------------------------------------------
module btsc_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  btsc_pkg::item_t                    head,
    input  btsc_pkg::q_stat_t                  q_stat,
    output logic                               pop,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [btsc_pkg::CH_W-1:0]          m_red,
    output logic [btsc_pkg::CH_W-1:0]          m_green,
    output logic [btsc_pkg::CH_W-1:0]          m_blue,
    output logic [btsc_pkg::CH_W-1:0]          m_alpha,
    output logic                               m_inside_res
);

    localparam int CB = btsc_pkg::COL_BITS;
    localparam int RB = btsc_pkg::ROW_BITS;
    localparam int FB = btsc_pkg::FRAC_BITS;
    localparam int NB = btsc_pkg::NUM_BANKS;
    localparam int AW = btsc_pkg::BANK_AW;
    localparam int TW = btsc_pkg::RGBA_W;
    localparam int LW = btsc_pkg::LERP_W;
    localparam int XW = btsc_pkg::ACC_W;
    localparam int WW = btsc_pkg::WGT_W;
    localparam int CW = btsc_pkg::CH_W;
    localparam int NC = btsc_pkg::NUM_CH;

    logic be;
    logic m_valid_reg;
    assign be  = !m_valid_reg || m_ready;
    assign pop = be && !q_stat.empty;

    // bank addressing: banks split by row and column parity
    logic [CB-1:0]   c1_w, col_even_w, col_odd_w;
    logic [RB-1:0]   r1_w, row_even_w, row_odd_w;
    logic [AW-1:0]   raddr_w [NB];
    logic [AW-1:0]   waddr_w;
    logic [NB-1:0]   wr_en_w;

    assign c1_w       = head.c0 + CB'(1);
    assign r1_w       = head.r0 + RB'(1);
    assign col_even_w = head.c0[0] ? c1_w : head.c0;
    assign col_odd_w  = head.c0[0] ? head.c0 : c1_w;
    assign row_even_w = head.r0[0] ? r1_w : head.r0;
    assign row_odd_w  = head.r0[0] ? head.r0 : r1_w;
    assign waddr_w    = {head.ld.row[RB-1:1], head.ld.col[CB-1:1]};

    always_comb begin
        for (int b = 0; b < NB; b++) begin
            raddr_w[b] = {((b / 2) != 0) ? row_odd_w[RB-1:1] : row_even_w[RB-1:1],
                          ((b % 2) != 0) ? col_odd_w[CB-1:1] : col_even_w[CB-1:1]};
            wr_en_w[b] = pop && (head.ld.action == btsc_pkg::ACT_LOAD)
                       && ({head.ld.row[0], head.ld.col[0]} == 2'(b));
        end
    end

    logic [TW-1:0] bank_mem [NB][btsc_pkg::BANK_DEPTH];
    logic [TW-1:0] rd_reg   [NB];

    always_ff @(posedge aclk) begin
        for (int b = 0; b < NB; b++) begin
            if (wr_en_w[b]) begin
                bank_mem[b][waddr_w] <= head.ld.rgba;
            end
            if (be) begin
                rd_reg[b] <= bank_mem[b][raddr_w[b]];
            end
        end
    end

    // fetch stage
    logic          b1_valid_reg;
    logic          b1_zero_reg;
    logic          b1_c0p_reg, b1_r0p_reg;
    logic [FB-1:0] b1_fx_reg, b1_fy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
        end else if (be) begin
            b1_valid_reg <= !q_stat.empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (be) begin
            b1_zero_reg <= (head.ld.action == btsc_pkg::ACT_LOAD) || !head.in_range;
            b1_c0p_reg  <= head.c0[0];
            b1_r0p_reg  <= head.r0[0];
            b1_fx_reg   <= head.fx;
            b1_fy_reg   <= head.fy;
        end
    end

    // route banks back to corner texels
    logic [TW-1:0] t00_w, t10_w, t01_w, t11_w;
    logic [TW-1:0] ta_w, tb_w, tc_w, td_w;
    logic          fxnz_w, fynz_w;

    always_comb begin
        case ({b1_r0p_reg, b1_c0p_reg})
            2'b00: begin
                t00_w = rd_reg[0]; t10_w = rd_reg[1]; t01_w = rd_reg[2]; t11_w = rd_reg[3];
            end
            2'b01: begin
                t00_w = rd_reg[1]; t10_w = rd_reg[0]; t01_w = rd_reg[3]; t11_w = rd_reg[2];
            end
            2'b10: begin
                t00_w = rd_reg[2]; t10_w = rd_reg[3]; t01_w = rd_reg[0]; t11_w = rd_reg[1];
            end
            default: begin
                t00_w = rd_reg[3]; t10_w = rd_reg[2]; t01_w = rd_reg[1]; t11_w = rd_reg[0];
            end
        endcase
    end

    // a zero fraction reuses the low texel
    assign fxnz_w = (b1_fx_reg != '0);
    assign fynz_w = (b1_fy_reg != '0);
    assign ta_w   = t00_w;
    assign tb_w   = fxnz_w ? t10_w : t00_w;
    assign tc_w   = fynz_w ? t01_w : t00_w;
    assign td_w   = fxnz_w ? (fynz_w ? t11_w : t10_w) : (fynz_w ? t01_w : t00_w);

    // horizontal blend
    logic [WW-1:0]         wx0_w, wx1_w;
    logic [NC-1:0][LW-1:0] lo_w, hi_w;

    assign wx1_w = WW'(b1_fx_reg);
    assign wx0_w = btsc_pkg::FRAC_ONE - wx1_w;

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            lo_w[c] = LW'((LW+1)'(wx0_w) * (LW+1)'(ta_w[c*CW +: CW])
                        + (LW+1)'(wx1_w) * (LW+1)'(tb_w[c*CW +: CW]));
            hi_w[c] = LW'((LW+1)'(wx0_w) * (LW+1)'(tc_w[c*CW +: CW])
                        + (LW+1)'(wx1_w) * (LW+1)'(td_w[c*CW +: CW]));
        end
    end

    logic                  b2_valid_reg;
    logic                  b2_zero_reg;
    logic [FB-1:0]         b2_fy_reg;
    logic [NC-1:0][LW-1:0] b2_lo_reg, b2_hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b2_valid_reg <= 1'b0;
        end else if (be) begin
            b2_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (be) begin
            b2_zero_reg <= b1_zero_reg;
            b2_fy_reg   <= b1_fy_reg;
            b2_lo_reg   <= lo_w;
            b2_hi_reg   <= hi_w;
        end
    end

    // vertical blend and truncation
    logic [WW-1:0]         wy0_w, wy1_w;
    logic [XW-1:0]         acc_w [NC];
    logic [NC-1:0][CW-1:0] ch_w;

    assign wy1_w = WW'(b2_fy_reg);
    assign wy0_w = btsc_pkg::FRAC_ONE - wy1_w;

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            acc_w[c] = XW'(wy0_w) * XW'(b2_lo_reg[c]) + XW'(wy1_w) * XW'(b2_hi_reg[c]);
            ch_w[c]  = acc_w[c][2*FB +: CW];
        end
    end

    logic [NC-1:0][CW-1:0] m_rgba_reg;
    logic                  m_inside_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (be) begin
            m_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (be) begin
            m_rgba_reg   <= b2_zero_reg ? '0 : ch_w;
            m_inside_reg <= !b2_zero_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_red        = m_rgba_reg[0];
    assign m_green      = m_rgba_reg[1];
    assign m_blue       = m_rgba_reg[2];
    assign m_alpha      = m_rgba_reg[3];
    assign m_inside_res = m_inside_reg;

endmodule

/* rtl/bilinear_texel_sampler_core.sv */
// path from input word to result word: input register, 29-stage mapping
// pipeline, queue, 3-stage fetch and blend; throughput: one word per cycle
// unless stalled; the divider yields one quotient bit per stage and the four
// corner texels come from four parity banks read in the same cycle
// reset: synchronous active-low aresetn empties all stages and the queue and
// restores the size and extent registers; the texel store is not cleared
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bilinear_texel_sampler_core
// rgba8 texel store with load words and bilinear sample words
// ---------------------------------------------------------------------------
module bilinear_texel_sampler_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    // input words
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_action,
    input  logic [btsc_pkg::IN_COL_W-1:0]         s_texel_col,
    input  logic [btsc_pkg::IN_ROW_W-1:0]         s_texel_row,
    input  logic [btsc_pkg::RGBA_W-1:0]           s_texel_rgba,
    input  logic signed [btsc_pkg::COORD_W-1:0]   s_point_x,
    input  logic signed [btsc_pkg::COORD_W-1:0]   s_point_y,

    // result words
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [btsc_pkg::CH_W-1:0]             m_red,
    output logic [btsc_pkg::CH_W-1:0]             m_green,
    output logic [btsc_pkg::CH_W-1:0]             m_blue,
    output logic [btsc_pkg::CH_W-1:0]             m_alpha,
    output logic                                  m_inside_res,

    // register writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [btsc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [btsc_pkg::COORD_W-1:0]          cfg_data
);

    // configuration registers, always ready
    logic [btsc_pkg::DIM_W-1:0]   image_width_reg, image_height_reg;
    logic [btsc_pkg::COORD_W-1:0] x_min_reg, y_min_reg, x_max_reg, y_max_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= btsc_pkg::DIM_W'(256);
            image_height_reg <= btsc_pkg::DIM_W'(256);
            x_min_reg        <= '0;
            y_min_reg        <= '0;
            x_max_reg        <= btsc_pkg::COORD_W'(65536);
            y_max_reg        <= btsc_pkg::COORD_W'(65536);
        end else if (cfg_valid) begin
            case (cfg_index)
                btsc_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[btsc_pkg::DIM_W-1:0];
                btsc_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[btsc_pkg::DIM_W-1:0];
                btsc_pkg::CFG_X_MIN:        x_min_reg        <= cfg_data;
                btsc_pkg::CFG_Y_MIN:        y_min_reg        <= cfg_data;
                btsc_pkg::CFG_X_MAX:        x_max_reg        <= cfg_data;
                btsc_pkg::CFG_Y_MAX:        y_max_reg        <= cfg_data;
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // front: accept and map, pushes one queue entry per word
    logic              q_push;
    btsc_pkg::item_t   q_word, q_head;
    btsc_pkg::q_stat_t q_stat;
    logic              q_pop;

    btsc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_texel_col  (s_texel_col),
        .s_texel_row  (s_texel_row),
        .s_texel_rgba (s_texel_rgba),
        .s_point_x    (s_point_x),
        .s_point_y    (s_point_y),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .x_min        (x_min_reg),
        .y_min        (y_min_reg),
        .x_max        (x_max_reg),
        .y_max        (y_max_reg),
        .q_stat       (q_stat),
        .q_push       (q_push),
        .q_word       (q_word)
    );

    // queue lets front and back stall independently
    btsc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_word (q_word),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    // back: store writes, texel reads, blend, output register
    btsc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (q_head),
        .q_stat       (q_stat),
        .pop          (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_alpha      (m_alpha),
        .m_inside_res (m_inside_res)
    );

endmodule
